/* hw/rtl/qtbm_pkg.sv */
// Shared types, constants and helper function of the quadtree code to bitmap unit.
package qtbm_pkg;

    localparam int ROWS = 64;
    localparam int ROW_W = $clog2(ROWS);
    localparam int CODE_W = 16;
    localparam logic [2:0] MAX_SIDE_LOG2 = 3'd6;

    // Division by five: floor(x * 52429 / 2^18) is exact for every 16-bit x.
    localparam logic [16:0] DIV5_MUL = 17'd52429;
    localparam int DIV5_SHIFT = 18;
    localparam int PROD_W = CODE_W + 17;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_PAINT = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [2:0] DIG_NW = 3'd1;
    localparam logic [2:0] DIG_NE = 3'd2;
    localparam logic [2:0] DIG_SW = 3'd3;
    localparam logic [2:0] DIG_SE = 3'd4;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] code;
        logic [5:0]  row_index;
    } in_word_t;

    typedef struct packed {
        logic [63:0] row_bits;
        logic        code_fits;
    } out_word_t;

    typedef struct packed {
        logic start;
        logic digit_step;
        logic paint_init;
        logic paint_rd;
        logic read_issue;
        logic read_cap;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       digit_zero;
        logic       too_deep;
        logic       last_row;
        logic       out_free;
    } dp_status_t;

    // A run of 2^len_log ones starting at bit position start.
    function automatic logic [63:0] span_mask(input logic [2:0] len_log,
                                              input logic [5:0] start);
        logic [63:0] ones;
        if (len_log >= MAX_SIDE_LOG2) begin
            ones = '1;
        end else begin
            ones = (64'd1 << (7'd1 << len_log)) - 64'd1;
        end
        return ones << start;
    endfunction

endpackage

/* hw/rtl/quadtree_code_to_bitmap_unit.sv */
// Top level of the quadtree code to bitmap unit: configuration register, controller, datapath.
//
//  channel | ports                      | word
//  --------+----------------------------+---------------------------------
//  input   | s_valid s_ready s_data     | op, code, row_index
//  result  | m_valid m_ready m_data     | row_bits, code_fits
//  config  | APB psel..pready           | side_log2 at byte address 0
//
// One item at a time. A paint first decodes its d nonzero digits (up to 6), then
// sweeps the 2^L rows of its block (L block size log2), as the bitmap memory
// merges one row per cycle, reading each row and writing the merged word back.
// Reset returns the bitmap to white at once through per-row written flags.
// A result waiting in the output register holds the controller in its final
// state, while the next word may still be accepted only after that hand-off.
module quadtree_code_to_bitmap_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  qtbm_pkg::in_word_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output qtbm_pkg::out_word_t  m_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [2:0]            side_log2_reg;
    logic [2:0]            eff_log2;
    qtbm_pkg::ctrl_cmd_t   cmd;
    qtbm_pkg::dp_status_t  status;

    assign pready = 1'b1;

    // Only one register exists, so every address in the range selects it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_log2_reg <= 3'd6;
        end else if (psel && penable && pwrite && paddr <= 2'd3) begin
            side_log2_reg <= pwdata[2:0];
        end
    end

    assign prdata = {29'd0, side_log2_reg};
    assign eff_log2 = (side_log2_reg > qtbm_pkg::MAX_SIDE_LOG2) ? qtbm_pkg::MAX_SIDE_LOG2
                                                                : side_log2_reg;

    qtbm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_op    (s_data.op),
        .status  (status),
        .s_ready (s_ready),
        .cmd     (cmd)
    );

    qtbm_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .s_item   (s_data),
        .eff_log2 (eff_log2),
        .m_ready  (m_ready),
        .status   (status),
        .m_valid  (m_valid),
        .m_item   (m_data)
    );

endmodule

/* hw/rtl/qtbm_datapath.sv */
// Datapath: digit decoder, block position registers, bitmap memory and result register.
module qtbm_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  qtbm_pkg::ctrl_cmd_t    cmd,
    input  qtbm_pkg::in_word_t     s_item,
    input  logic [2:0]             eff_log2,
    input  logic                   m_ready,
    output qtbm_pkg::dp_status_t   status,
    output logic                   m_valid,
    output qtbm_pkg::out_word_t    m_item
);

    logic [1:0]               op_reg;
    logic [15:0]              code_reg;
    logic [5:0]               row_reg;
    logic [2:0]               len_log_reg;
    logic [5:0]               r0_reg;
    logic [5:0]               c0_reg;
    logic [63:0]              mask_reg;
    logic [5:0]               row_cnt_reg;
    logic [6:0]               rows_left_reg;
    logic                     wr_pend_reg;
    logic [5:0]               wr_addr_reg;
    logic [63:0]              mem [qtbm_pkg::ROWS];
    logic [qtbm_pkg::ROWS-1:0] vld_reg;
    logic [63:0]              rd_data_reg;
    logic                     rd_vld_reg;
    logic                     out_valid_reg;
    logic [63:0]              res_bits_reg;
    logic                     res_fits_reg;

    logic [qtbm_pkg::PROD_W-1:0] prod;
    logic [15:0]              quo;
    logic [15:0]              quo5;
    logic [2:0]               digit;
    logic [5:0]               half;
    logic                     rd_en;
    logic [5:0]               rd_addr;
    logic [63:0]              wr_data;
    logic [6:0]               side;

    // One base-5 digit per cycle: quotient by reciprocal multiply, digit as remainder.
    assign prod = qtbm_pkg::PROD_W'(code_reg) * qtbm_pkg::PROD_W'(qtbm_pkg::DIV5_MUL);
    assign quo = 16'(prod[qtbm_pkg::PROD_W-1:qtbm_pkg::DIV5_SHIFT]);
    assign quo5 = {quo[13:0], 2'b00} + quo;
    assign digit = code_reg[2:0] - quo5[2:0];
    assign half = 6'(7'd1 << (len_log_reg - 3'd1));

    assign rd_en = cmd.paint_rd | cmd.read_issue;
    assign rd_addr = cmd.paint_rd ? row_cnt_reg : row_reg;
    assign wr_data = (rd_vld_reg ? rd_data_reg : 64'd0) | mask_reg;
    assign side = 7'(8'd1 << eff_log2);

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg <= s_item.op;
            code_reg <= s_item.code;
            row_reg <= s_item.row_index;
            len_log_reg <= eff_log2;
            r0_reg <= '0;
            c0_reg <= '0;
        end else if (cmd.digit_step) begin
            code_reg <= quo;
            len_log_reg <= len_log_reg - 3'd1;
            if (digit == qtbm_pkg::DIG_NE || digit == qtbm_pkg::DIG_SE) begin
                c0_reg <= c0_reg + half;
            end
            if (digit == qtbm_pkg::DIG_SW || digit == qtbm_pkg::DIG_SE) begin
                r0_reg <= r0_reg + half;
            end
        end
        if (cmd.paint_init) begin
            mask_reg <= qtbm_pkg::span_mask(len_log_reg, c0_reg);
            row_cnt_reg <= r0_reg;
            rows_left_reg <= 7'(8'd1 << len_log_reg);
        end else if (cmd.paint_rd) begin
            row_cnt_reg <= row_cnt_reg + 6'd1;
            rows_left_reg <= rows_left_reg - 7'd1;
        end
        wr_addr_reg <= row_cnt_reg;
    end

    // Bitmap rows: each row is read, then merged and written back in the next cycle.
    always_ff @(posedge aclk) begin
        if (wr_pend_reg) begin
            mem[wr_addr_reg] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_pend_reg <= 1'b0;
            vld_reg <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            wr_pend_reg <= cmd.paint_rd;
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
            if (cmd.start && s_item.op == qtbm_pkg::OP_CLEAR) begin
                vld_reg <= '0;
            end else if (wr_pend_reg) begin
                vld_reg[wr_addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            res_bits_reg <= '0;
            res_fits_reg <= 1'b0;
        end else begin
            if (cmd.paint_init) begin
                res_fits_reg <= 1'b1;
            end
            if (cmd.read_cap && {1'b0, row_reg} < side) begin
                res_bits_reg <= (rd_vld_reg ? rd_data_reg : 64'd0)
                                & qtbm_pkg::span_mask(eff_log2, 6'd0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_item.row_bits <= res_bits_reg;
            m_item.code_fits <= res_fits_reg;
        end
    end

    assign m_valid = out_valid_reg;

    always_comb begin
        status.op = op_reg;
        status.digit_zero = (digit == 3'd0);
        status.too_deep = (len_log_reg == 3'd0);
        status.last_row = (rows_left_reg == 7'd1);
        status.out_free = !out_valid_reg || m_ready;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_pend_reg |-> $past(cmd.paint_rd))
        else $error("bitmap write without a preceding row read");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!out_valid_reg || m_ready))
        else $error("result register overwritten before it was taken");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.start && s_item.op == qtbm_pkg::OP_CLEAR) |=> (vld_reg == '0))
        else $error("clear left a row marked as written");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.digit_step |-> (len_log_reg != 3'd0 && digit != 3'd0))
        else $error("descent past single pixel or on an end digit");

endmodule

/* hw/rtl/qtbm_ctrl.sv */
// Controller state machine: sequences decode, row painting, row reads and result hand-off.
module qtbm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic [1:0]            s_op,
    input  qtbm_pkg::dp_status_t  status,
    output logic                  s_ready,
    output qtbm_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIGIT,
        ST_PAINT,
        ST_DRAIN,
        ST_READ,
        ST_RDCAP,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.start = 1'b1;
                    case (s_op)
                        qtbm_pkg::OP_PAINT: state_next = ST_DIGIT;
                        qtbm_pkg::OP_READ:  state_next = ST_READ;
                        default:            state_next = ST_FINISH;
                    endcase
                end
            end
            ST_DIGIT: begin
                if (status.digit_zero) begin
                    cmd.paint_init = 1'b1;
                    state_next = ST_PAINT;
                end else if (status.too_deep) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.digit_step = 1'b1;
                end
            end
            ST_PAINT: begin
                cmd.paint_rd = 1'b1;
                if (status.last_row) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // The last row's merged word is written during this cycle.
                state_next = ST_FINISH;
            end
            ST_READ: begin
                cmd.read_issue = 1'b1;
                state_next = ST_RDCAP;
            end
            ST_RDCAP: begin
                cmd.read_cap = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> $past(state_reg == ST_PAINT && status.last_row))
        else $error("drain entered without finishing the row sweep");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PAINT) |-> (status.op == qtbm_pkg::OP_PAINT))
        else $error("row sweep for an item that is not a paint");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RDCAP) |-> $past(state_reg == ST_READ))
        else $error("read capture without a read issue");

endmodule

/* bench/quadtree_code_to_bitmap_unit_tb.sv */
// Self-checking testbench of the quadtree code to bitmap unit.
module quadtree_code_to_bitmap_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ADDR_SIDE_LOG2 = 2'd0;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_WORDS = 88;
    localparam int STEADY_FIRST = 250;
    localparam int STEADY_LAST = 349;
    localparam int N_DIRECTED = 22;
    localparam int N_PHASES = 8;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] code;
        logic [5:0]  row_index;
        logic        pinned;
        logic [63:0] row_bits;
        logic        code_fits;
    } directed_row_t;

    // Rows with pinned set carry their expected result; the others are checked against the shadow bitmap.
    localparam directed_row_t DIRECTED [N_DIRECTED] = '{
        '{qtbm_pkg::OP_READ,  16'd0,     6'd0,  1'b1, 64'd0,                  1'b0},
        '{qtbm_pkg::OP_PAINT, 16'd0,     6'd0,  1'b1, 64'd0,                  1'b1},
        '{qtbm_pkg::OP_READ,  16'd0,     6'd63, 1'b1, '1,                     1'b0},
        '{qtbm_pkg::OP_READ,  16'hFFFF,  6'd0,  1'b1, '1,                     1'b0},
        '{qtbm_pkg::OP_NONE,  16'hFFFF,  6'd63, 1'b1, 64'd0,                  1'b0},
        '{qtbm_pkg::OP_CLEAR, 16'hFFFF,  6'd63, 1'b1, 64'd0,                  1'b0},
        '{qtbm_pkg::OP_READ,  16'd0,     6'd31, 1'b1, 64'd0,                  1'b0},
        '{qtbm_pkg::OP_PAINT, 16'd19531, 6'd0,  1'b1, 64'd0,                  1'b0},
        '{qtbm_pkg::OP_PAINT, 16'd15624, 6'd0,  1'b1, 64'd0,                  1'b1},
        '{qtbm_pkg::OP_READ,  16'd0,     6'd63, 1'b1, 64'h8000_0000_0000_0000, 1'b0},
        '{qtbm_pkg::OP_PAINT, 16'd1,     6'd0,  1'b0, 64'd0,                  1'b0},
        '{qtbm_pkg::OP_PAINT, 16'd7,     6'd0,  1'b0, 64'd0,                  1'b0},
        '{qtbm_pkg::OP_PAINT, 16'd3,     6'd0,  1'b0, 64'd0,                  1'b0},
        '{qtbm_pkg::OP_PAINT, 16'd19,    6'd0,  1'b0, 64'd0,                  1'b0},
        '{qtbm_pkg::OP_READ,  16'd0,     6'd0,  1'b0, 64'd0,                  1'b0},
        '{qtbm_pkg::OP_READ,  16'd0,     6'd40, 1'b0, 64'd0,                  1'b0},
        '{qtbm_pkg::OP_READ,  16'd0,     6'd48, 1'b0, 64'd0,                  1'b0},
        '{qtbm_pkg::OP_PAINT, 16'hFFFF,  6'd0,  1'b0, 64'd0,                  1'b0},
        '{qtbm_pkg::OP_READ,  16'd0,     6'd10, 1'b0, 64'd0,                  1'b0},
        '{qtbm_pkg::OP_CLEAR, 16'd0,     6'd0,  1'b1, 64'd0,                  1'b0},
        '{qtbm_pkg::OP_PAINT, 16'd24,    6'd0,  1'b0, 64'd0,                  1'b0},
        '{qtbm_pkg::OP_READ,  16'd0,     6'd63, 1'b0, 64'd0,                  1'b0}
    };

    localparam logic [2:0] PHASE_SIDES [N_PHASES] = '{
        3'd7, 3'd0, 3'd1, 3'd3, 3'd5, 3'd2, 3'd4, 3'd6
    };

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    qtbm_pkg::in_word_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    qtbm_pkg::out_word_t m_data;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [1:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    // Shadow copy of the bitmap and the side register.
    logic [63:0] shadow_rows [64];
    logic [2:0]  shadow_side;

    qtbm_pkg::out_word_t pending_results [$];
    int          mismatches = 0;
    int          cycles = 0;
    int          words_sent = 0;
    int          results_checked = 0;
    int          deep_codes = 0;
    bit          steady = 1'b0;

    quadtree_code_to_bitmap_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 aclk = ~aclk;

    function automatic int side_log2_in_use();
        return (shadow_side > 3'd6) ? 6 : int'(shadow_side);
    endfunction

    function automatic logic [63:0] ones_run(int len, int start);
        logic [63:0] run;
        if (len >= 64) begin
            run = '1;
        end else begin
            run = (64'd1 << len) - 64'd1;
        end
        return run << start;
    endfunction

    // Applies one word to the shadow bitmap and returns the result it gives.
    function automatic qtbm_pkg::out_word_t bitmap_step(qtbm_pkg::in_word_t w);
        qtbm_pkg::out_word_t res;
        int side;
        int len;
        int r0;
        int c0;
        int digit;
        int rest;
        logic [63:0] cols;
        res = '0;
        side = 1 << side_log2_in_use();
        case (w.op)
            qtbm_pkg::OP_CLEAR: begin
                for (int r = 0; r < 64; r++) shadow_rows[r] = '0;
            end
            qtbm_pkg::OP_PAINT: begin
                len = side;
                r0 = 0;
                c0 = 0;
                rest = int'(w.code);
                res.code_fits = 1'b1;
                for (int lvl = 0; lvl < 8; lvl++) begin
                    digit = rest % 5;
                    rest = rest / 5;
                    if (digit == 0) break;
                    if (len <= 1) begin
                        res.code_fits = 1'b0;
                        break;
                    end
                    len = len >> 1;
                    if (digit == int'(qtbm_pkg::DIG_NE) ||
                        digit == int'(qtbm_pkg::DIG_SE)) c0 += len;
                    if (digit == int'(qtbm_pkg::DIG_SW) ||
                        digit == int'(qtbm_pkg::DIG_SE)) r0 += len;
                end
                if (res.code_fits) begin
                    cols = ones_run(len, c0);
                    for (int r = r0; r < r0 + len && r < 64; r++) begin
                        shadow_rows[r] |= cols;
                    end
                end
            end
            qtbm_pkg::OP_READ: begin
                if (int'(w.row_index) < side) begin
                    res.row_bits = shadow_rows[w.row_index] & ones_run(side, 0);
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic void note_failure(string what, logic [63:0] exp_bits, logic exp_fits,
                                         logic [63:0] got_bits, logic got_fits);
        mismatches++;
        if (mismatches <= 10) begin
            $display("MISMATCH %s at cycle %0d: expected bits=%h fits=%b, got bits=%h fits=%b",
                     what, cycles, exp_bits, exp_fits, got_bits, got_fits);
        end
    endfunction

    // Mostly well-formed paths of random depth, some fully random codes.
    function automatic logic [15:0] random_code();
        int depth;
        int weight;
        int value;
        if ($urandom_range(0, 4) == 0) return 16'($urandom_range(0, 65535));
        depth = $urandom_range(0, side_log2_in_use() + 1);
        if (depth > 6) depth = 6;
        value = 0;
        weight = 1;
        for (int k = 0; k < depth; k++) begin
            value += $urandom_range(1, 4) * weight;
            weight *= 5;
        end
        // Skip the terminating zero digit, then fill the digits above it at random.
        weight *= 5;
        if (weight <= 65535) value += weight * $urandom_range(0, (65535 - value) / weight);
        return 16'(value);
    endfunction

    function automatic qtbm_pkg::in_word_t random_word();
        qtbm_pkg::in_word_t w;
        int pick;
        pick = $urandom_range(0, 99);
        w.code = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 1) == 0) begin
            w.row_index = 6'($urandom_range(0, (1 << side_log2_in_use()) - 1));
        end else begin
            w.row_index = 6'($urandom_range(0, 63));
        end
        if (pick < 4) begin
            w.op = qtbm_pkg::OP_CLEAR;
        end else if (pick < 9) begin
            w.op = qtbm_pkg::OP_NONE;
        end else if (pick < 55) begin
            w.op = qtbm_pkg::OP_PAINT;
            w.code = random_code();
        end else begin
            w.op = qtbm_pkg::OP_READ;
        end
        return w;
    endfunction

    // Offers one word, waits for its acceptance and records what it should give.
    task automatic send_word(qtbm_pkg::in_word_t w, logic pinned,
                             qtbm_pkg::out_word_t pinned_res);
        qtbm_pkg::out_word_t res;
        if (!steady && $urandom_range(0, 99) < 32) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < 32) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        res = bitmap_step(w);
        if (pinned) res = pinned_res;
        if (w.op == qtbm_pkg::OP_PAINT && !res.code_fits) deep_codes++;
        pending_results.push_back(res);
        words_sent++;
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic set_side_log2(logic [2:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_SIDE_LOG2;
        pwdata <= {29'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        shadow_side = value;
        // Read the register back.
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== {29'd0, value}) begin
            note_failure("register readback", {61'd0, value}, 1'b0, {32'd0, prdata}, 1'b0);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycles, pending_results.size());
            $display("quadtree_code_to_bitmap_unit test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(0, 99) >= 32);
        end
    end

    always @(posedge aclk) begin
        qtbm_pkg::out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                note_failure("unexpected word", '0, 1'b0, m_data.row_bits, m_data.code_fits);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (m_data.row_bits !== want.row_bits || m_data.code_fits !== want.code_fits) begin
                    note_failure("result", want.row_bits, want.code_fits,
                                 m_data.row_bits, m_data.code_fits);
                end
            end
        end
    end

    initial begin
        qtbm_pkg::in_word_t w;
        qtbm_pkg::out_word_t fixed_res;
        int random_index;
        for (int r = 0; r < 64; r++) shadow_rows[r] = '0;
        shadow_side = 3'd6;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            w.op = DIRECTED[i].op;
            w.code = DIRECTED[i].code;
            w.row_index = DIRECTED[i].row_index;
            fixed_res.row_bits = DIRECTED[i].row_bits;
            fixed_res.code_fits = DIRECTED[i].code_fits;
            send_word(w, DIRECTED[i].pinned, fixed_res);
        end

        // Stored pixels survive a smaller side, so reads also test column masking.
        random_index = 0;
        for (int p = 0; p < N_PHASES; p++) begin
            drain_results();
            set_side_log2(PHASE_SIDES[p]);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                steady = (random_index >= STEADY_FIRST && random_index <= STEADY_LAST);
                send_word(random_word(), 1'b0, '0);
                random_index++;
            end
        end
        steady = 1'b0;
        drain_results();
        repeat (80) @(posedge aclk);

        if (pending_results.size() != 0) begin
            mismatches += pending_results.size();
            $display("%0d expected results never arrived", pending_results.size());
        end
        $display("Sent %0d words over %0d side settings plus the reset side; checked %0d results.",
                 words_sent, N_PHASES, results_checked);
        $display("%0d paint codes went deeper than one pixel; %0d mismatches in all.",
                 deep_codes, mismatches);
        if (mismatches == 0) begin
            $display("quadtree_code_to_bitmap_unit test passed");
        end else begin
            $display("quadtree_code_to_bitmap_unit test failed");
        end
        $finish;
    end

endmodule
